// ===== rtl/core/ckab_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ckab_pkg
// Shared types and codes for the colour-keyed alpha blit pixel compositor.
// ----------------------------------------------------------------------------
package ckab_pkg;

	localparam int unsigned PIXEL_W   = 32;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned KEY_W     = 24;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 24;

	// pixel_mode codes; bit 1 set selects blending (so code 3 blends too)
	localparam logic [MODE_W-1:0] MODE_INDEX8 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ARGB   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BLEND  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOUR = 2'd2;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;
	localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

	typedef struct packed {
		logic [MODE_W-1:0] pixel_mode;
		logic              key_enable;
		logic [KEY_W-1:0]  key_colour;
	} cfg_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] out_pixel;
		logic               write_enable;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/ckab_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ckab_if
// Valid/ready channels for source/destination pixel pairs and results.
// ----------------------------------------------------------------------------
interface ckab_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [ckab_pkg::PIXEL_W-1:0]         src_pixel;
	logic [ckab_pkg::PIXEL_W-1:0]         dest_pixel;
	logic                                 last_pixel;

	modport source (output valid, src_pixel, dest_pixel, last_pixel, input ready);
	modport sink   (input valid, src_pixel, dest_pixel, last_pixel, output ready);
endinterface

interface ckab_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [ckab_pkg::PIXEL_W-1:0]         out_pixel;
	logic                                 write_enable;
	logic                                 last_out;

	modport source (output valid, out_pixel, write_enable, last_out, input ready);
	modport sink   (input valid, out_pixel, write_enable, last_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ckab_compose.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ckab_compose
// Combinational per-pixel compose: colour key, index/argb copy, alpha blend.
// ----------------------------------------------------------------------------
module ckab_compose (
	input  wire ckab_pkg::cfg_t                cfg,
	input  wire [ckab_pkg::PIXEL_W-1:0]        src_pixel,
	input  wire [ckab_pkg::PIXEL_W-1:0]        dest_pixel,
	output ckab_pkg::result_t                  result
);

	// floor((s - d) * a / 256) + d; the arithmetic shift gives the floor
	function automatic logic [ckab_pkg::CHAN_W-1:0] blend_chan(
		input logic [ckab_pkg::CHAN_W-1:0] s,
		input logic [ckab_pkg::CHAN_W-1:0] d,
		input logic [ckab_pkg::CHAN_W-1:0] a
	);
		logic signed [ckab_pkg::CHAN_W:0]       diff;
		logic signed [2*ckab_pkg::CHAN_W+1:0]   prod;
		logic signed [2*ckab_pkg::CHAN_W+1:0]   shr;
		diff = $signed({1'b0, s}) - $signed({1'b0, d});
		prod = diff * $signed({1'b0, a});
		shr  = prod >>> ckab_pkg::CHAN_W;
		return shr[ckab_pkg::CHAN_W-1:0] + d;
	endfunction

	logic                          is_index;
	logic                          is_blend;
	logic                          keyed;
	logic [ckab_pkg::CHAN_W-1:0]   sa;
	logic [ckab_pkg::CHAN_W-1:0]   da;
	logic [ckab_pkg::CHAN_W:0]     asum;
	logic [ckab_pkg::CHAN_W-1:0]   anew;
	logic [ckab_pkg::PIXEL_W-1:0]  blended;

	assign is_index = (cfg.pixel_mode == ckab_pkg::MODE_INDEX8);
	assign is_blend = cfg.pixel_mode[1];
	assign sa       = src_pixel[31:24];
	assign da       = dest_pixel[31:24];
	assign asum     = {1'b0, sa} + {1'b0, da};
	assign anew     = asum[ckab_pkg::CHAN_W] ? ckab_pkg::ALPHA_OPAQUE
		: asum[ckab_pkg::CHAN_W-1:0];

	assign keyed = cfg.key_enable && (is_index
		? (src_pixel[7:0] == cfg.key_colour[7:0])
		: (src_pixel[23:0] == cfg.key_colour));

	assign blended = {anew,
		blend_chan(src_pixel[23:16], dest_pixel[23:16], sa),
		blend_chan(src_pixel[15:8],  dest_pixel[15:8],  sa),
		blend_chan(src_pixel[7:0],   dest_pixel[7:0],   sa)};

	always_comb begin
		result.out_pixel    = dest_pixel;
		result.write_enable = 1'b0;
		if (!keyed) begin
			if (is_index) begin
				result.out_pixel    = {24'd0, src_pixel[7:0]};
				result.write_enable = 1'b1;
			end else if (!is_blend || sa == ckab_pkg::ALPHA_OPAQUE) begin
				result.out_pixel    = src_pixel;
				result.write_enable = 1'b1;
			end else if (sa != ckab_pkg::ALPHA_CLEAR) begin
				result.out_pixel    = blended;
				result.write_enable = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/colour_key_alpha_blit_pixel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// colour_key_alpha_blit_pixel
// Per-pixel compositor for block copies: keyed copy and alpha blend.
// ----------------------------------------------------------------------------
// One pixel pair enters per clock and its result passes through
// an input register, one pass of compose logic (three 9x9 multiplies for the
// blend), and an output register. Both stages stall in place under output
// backpressure, so a sustained rate of one pixel per cycle holds whenever the
// sink keeps ready high. Configuration writes take effect at once and must
// only be issued with the pipeline empty.
module colour_key_alpha_blit_pixel (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [ckab_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [ckab_pkg::CFG_DAT_W-1:0]      cfg_data,
	ckab_in_if.sink                            pix_in,
	ckab_out_if.source                         pix_out
);

	ckab_pkg::cfg_t                 cfg_q;

	logic                           vld_s1;
	logic [ckab_pkg::PIXEL_W-1:0]   src_s1;
	logic [ckab_pkg::PIXEL_W-1:0]   dst_s1;
	logic                           last_s1;

	logic                           vld_s2;
	ckab_pkg::result_t              res_s2;
	logic                           last_s2;

	ckab_pkg::result_t              res_c;
	logic                           adv_s2;
	logic                           adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_mode <= ckab_pkg::MODE_ARGB;
			cfg_q.key_enable <= 1'b0;
			cfg_q.key_colour <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ckab_pkg::CFG_PIXEL_MODE: cfg_q.pixel_mode <= cfg_data[ckab_pkg::MODE_W-1:0];
				ckab_pkg::CFG_KEY_ENABLE: cfg_q.key_enable <= cfg_data[0];
				ckab_pkg::CFG_KEY_COLOUR: cfg_q.key_colour <= cfg_data[ckab_pkg::KEY_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv_s2       = !vld_s2 || pix_out.ready;
	assign adv_s1       = !vld_s1 || adv_s2;
	assign pix_in.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				vld_s1 <= pix_in.valid;
			if (adv_s2)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pix_in.valid) begin
			src_s1  <= pix_in.src_pixel;
			dst_s1  <= pix_in.dest_pixel;
			last_s1 <= pix_in.last_pixel;
		end
		if (adv_s2 && vld_s1) begin
			res_s2  <= res_c;
			last_s2 <= last_s1;
		end
	end

	ckab_compose u_compose (
		.cfg        (cfg_q),
		.src_pixel  (src_s1),
		.dest_pixel (dst_s1),
		.result     (res_c)
	);

	assign pix_out.valid        = vld_s2;
	assign pix_out.out_pixel    = res_s2.out_pixel;
	assign pix_out.write_enable = res_s2.write_enable;
	assign pix_out.last_out     = last_s2;

	// a stalled first stage keeps its transaction
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv_s2 |=> vld_s1 && $stable(src_s1) && $stable(dst_s1))
		else $error("stage 1 transaction lost under stall");

	// both stages full and sink stalled: no new transaction may enter
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 && !pix_out.ready |-> !pix_in.ready)
		else $error("input accepted with pipeline full");

	// a stage-1 transaction reaches the output the cycle after it moves
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s2 |=> vld_s2)
		else $error("transaction dropped between stages");

	// index mode writes only carry the low byte
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.write_enable && cfg_q.pixel_mode == ckab_pkg::MODE_INDEX8
		|-> res_s2.out_pixel[31:8] == 24'd0)
		else $error("index mode result has upper bits set");

endmodule
`default_nettype wire

// ===== dv/ckab_blit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ckab_blit_checker
// Watches register writes and both pixel channels. Keeps its own copy of the
// registers, predicts the composited pixel for every accepted pair and checks
// results in arrival order.
// ----------------------------------------------------------------------------
module ckab_blit_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [ckab_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [ckab_pkg::CFG_DAT_W-1:0] cfg_data,
	ckab_in_if                            pix_in,
	ckab_out_if                           pix_out,
	output int                            fail_count,
	output int                            pending_count,
	output int                            checked_count
);

	typedef struct packed {
		logic [ckab_pkg::PIXEL_W-1:0] pixel;
		logic                         write;
		logic                         last;
	} blit_write_t;

	logic [ckab_pkg::MODE_W-1:0] mode_q;
	logic                        key_en_q;
	logic [ckab_pkg::KEY_W-1:0]  key_q;
	blit_write_t                 expected_writes[$];

	// floor(((s - d) * a) / 256) + d; arithmetic shift on a signed int floors
	function automatic logic [ckab_pkg::CHAN_W-1:0] mix_channel(
			input logic [ckab_pkg::CHAN_W-1:0] s,
			input logic [ckab_pkg::CHAN_W-1:0] d,
			input logic [ckab_pkg::CHAN_W-1:0] a);
		int diff;
		int mixed;
		diff = (int'(s) - int'(d)) * int'(a);
		mixed = (diff >>> 8) + int'(d);
		return mixed[ckab_pkg::CHAN_W-1:0];
	endfunction

	function automatic blit_write_t composite_pixel(input logic [ckab_pkg::PIXEL_W-1:0] src,
			input logic [ckab_pkg::PIXEL_W-1:0] dst, input logic last);
		blit_write_t                 res;
		logic [ckab_pkg::CHAN_W-1:0] sa;
		logic [ckab_pkg::CHAN_W-1:0] da;
		logic [ckab_pkg::CHAN_W:0]   alpha_sum;
		res.pixel = dst;
		res.write = 1'b0;
		res.last  = last;
		sa = src[31:24];
		da = dst[31:24];
		if (mode_q == ckab_pkg::MODE_INDEX8) begin
			if (!(key_en_q && src[7:0] == key_q[7:0])) begin
				res.pixel = {24'd0, src[7:0]};
				res.write = 1'b1;
			end
		end else if (!(key_en_q && src[23:0] == key_q)) begin
			if (mode_q == ckab_pkg::MODE_ARGB || sa == ckab_pkg::ALPHA_OPAQUE) begin
				res.pixel = src;
				res.write = 1'b1;
			end else if (sa != ckab_pkg::ALPHA_CLEAR) begin
				alpha_sum = {1'b0, sa} + {1'b0, da};
				res.pixel[31:24] = alpha_sum[ckab_pkg::CHAN_W] ? ckab_pkg::ALPHA_OPAQUE
					: alpha_sum[ckab_pkg::CHAN_W-1:0];
				for (int c = 0; c < 3; c++)
					res.pixel[c*ckab_pkg::CHAN_W +: ckab_pkg::CHAN_W] = mix_channel(
						src[c*ckab_pkg::CHAN_W +: ckab_pkg::CHAN_W],
						dst[c*ckab_pkg::CHAN_W +: ckab_pkg::CHAN_W], sa);
				res.write = 1'b1;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [ckab_pkg::PIXEL_W-1:0] got,
			input logic [ckab_pkg::PIXEL_W-1:0] want);
		$display("%t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		blit_write_t want;
		if (!arst_n) begin
			mode_q        = ckab_pkg::MODE_ARGB;
			key_en_q      = 1'b0;
			key_q         = '0;
			fail_count    = 0;
			checked_count = 0;
			expected_writes.delete();
			pending_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ckab_pkg::CFG_PIXEL_MODE: mode_q = cfg_data[ckab_pkg::MODE_W-1:0];
					ckab_pkg::CFG_KEY_ENABLE: key_en_q = cfg_data[0];
					ckab_pkg::CFG_KEY_COLOUR: key_q = cfg_data[ckab_pkg::KEY_W-1:0];
					default: ;
				endcase
			end
			if (pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
				checked_count++;
				if (expected_writes.size() == 0) begin
					report_mismatch("result with no pixel outstanding", pix_out.out_pixel, 'x);
				end else begin
					want = expected_writes.pop_front();
					if (pix_out.out_pixel !== want.pixel)
						report_mismatch("out_pixel", pix_out.out_pixel, want.pixel);
					if (pix_out.write_enable !== want.write)
						report_mismatch("write_enable",
							{{(ckab_pkg::PIXEL_W-1){1'b0}}, pix_out.write_enable},
							{{(ckab_pkg::PIXEL_W-1){1'b0}}, want.write});
					if (pix_out.last_out !== want.last)
						report_mismatch("last_out",
							{{(ckab_pkg::PIXEL_W-1){1'b0}}, pix_out.last_out},
							{{(ckab_pkg::PIXEL_W-1){1'b0}}, want.last});
				end
			end
			if (pix_in.valid === 1'b1 && pix_in.ready === 1'b1)
				expected_writes.push_back(composite_pixel(pix_in.src_pixel,
					pix_in.dest_pixel, pix_in.last_pixel));
			pending_count = expected_writes.size();
		end
	end

endmodule

// ===== dv/colour_key_alpha_blit_pixel_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// colour_key_alpha_blit_pixel_tb
// Drives pixel pairs through the blit compositor under a series of register
// settings: a directed set of edge cases, then random pixels with random
// gaps and stalls on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module colour_key_alpha_blit_pixel_tb;

	localparam logic [ckab_pkg::MODE_W-1:0] MODE_BLEND_ALT = 2'd3;  // bit 1 set, blends too
	localparam int CLK_HALF        = 5;
	localparam int PIXEL_TOTAL     = 550;
	localparam int CALM_TAIL       = 60;
	localparam int PRESSURE_AT     = 200;
	localparam int PRESSURE_CYCLES = 64;
	localparam int CYCLE_LIMIT     = 200000;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [ckab_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ckab_pkg::CFG_DAT_W-1:0] cfg_data;
	logic                           idle_on;
	logic                           hold_off;
	int                             fail_count;
	int                             pending_count;
	int                             checked_count;
	int                             sent_count;
	int                             setting_count;
	int                             cycle_count;

	ckab_in_if  pix_in_ch();
	ckab_out_if pix_out_ch();

	colour_key_alpha_blit_pixel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix_in_ch),
		.pix_out   (pix_out_ch)
	);

	ckab_blit_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pix_in        (pix_in_ch),
		.pix_out       (pix_out_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_pixel(input logic [ckab_pkg::PIXEL_W-1:0] src,
			input logic [ckab_pkg::PIXEL_W-1:0] dst, input logic last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			pix_in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		pix_in_ch.valid      <= 1'b1;
		pix_in_ch.src_pixel  <= src;
		pix_in_ch.dest_pixel <= dst;
		pix_in_ch.last_pixel <= last;
		do @(posedge clk); while (pix_in_ch.ready !== 1'b1);
		sent_count++;
	endtask

	task automatic send_random_pixel(input logic [ckab_pkg::MODE_W-1:0] mode,
			input logic [ckab_pkg::KEY_W-1:0] key);
		logic [ckab_pkg::PIXEL_W-1:0] src;
		logic [ckab_pkg::PIXEL_W-1:0] dst;
		src = $urandom();
		dst = $urandom();
		// steer a fifth of the pixels onto the key
		if ($urandom_range(0, 9) < 2) begin
			if (mode == ckab_pkg::MODE_INDEX8)
				src[7:0] = key[7:0];
			else
				src[23:0] = key;
		end
		case ($urandom_range(0, 9))
			0: src[31:24] = ckab_pkg::ALPHA_CLEAR;
			1: src[31:24] = ckab_pkg::ALPHA_OPAQUE;
			2: src[31:24] = 8'h01;
			3: src[31:24] = 8'hfe;
			default: ;
		endcase
		send_pixel(src, dst, $urandom_range(0, 15) == 0);
	endtask

	// wait for the pipeline to empty
	task automatic drain();
		pix_in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ckab_pkg::CFG_IDX_W-1:0] idx,
			input logic [ckab_pkg::CFG_DAT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [ckab_pkg::MODE_W-1:0] mode, input logic en,
			input logic [ckab_pkg::KEY_W-1:0] key);
		drain();
		write_reg(ckab_pkg::CFG_PIXEL_MODE,
			{{(ckab_pkg::CFG_DAT_W-ckab_pkg::MODE_W){1'b0}}, mode});
		write_reg(ckab_pkg::CFG_KEY_ENABLE, {{(ckab_pkg::CFG_DAT_W-1){1'b0}}, en});
		write_reg(ckab_pkg::CFG_KEY_COLOUR, key);
		cfg_we <= 1'b0;
		setting_count++;
	endtask

	initial begin : sink
		int stall_left;
		stall_left = 0;
		pix_out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0)
				stall_left--;
			else if (idle_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 7);
			pix_out_ch.ready <= !hold_off && stall_left == 0;
		end
	end

	// one long hold-off so the pipeline fills and backs up the input
	initial begin : pressure
		hold_off <= 1'b0;
		wait (sent_count >= PRESSURE_AT);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (PRESSURE_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin : stimulus
		logic [ckab_pkg::MODE_W-1:0] mode;
		logic                        en;
		logic [ckab_pkg::KEY_W-1:0]  key;
		logic [31:0]                 rnd;
		logic                        phase_idle;
		int                          pick;
		int                          count;
		int                          phase;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= ckab_pkg::CFG_PIXEL_MODE;
		cfg_data             <= '0;
		idle_on              <= 1'b1;
		pix_in_ch.valid      <= 1'b0;
		pix_in_ch.src_pixel  <= '0;
		pix_in_ch.dest_pixel <= '0;
		pix_in_ch.last_pixel <= 1'b0;
		setting_count = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: plain copy, keying off; zero source equals the zero key
		send_pixel(32'h00000000, 32'hffffffff, 1'b0);
		send_pixel(32'hffffffff, 32'h00000000, 1'b1);
		send_pixel(32'h89abcdef, 32'h01234567, 1'b0);

		// index copy: only the low byte is keyed and kept
		apply_setting(ckab_pkg::MODE_INDEX8, 1'b1, 24'h12345a);
		send_pixel(32'hffffff5a, 32'h76543210, 1'b0);
		send_pixel(32'h0000005b, 32'hffffffff, 1'b0);
		send_pixel(32'hffffffff, 32'h00000000, 1'b1);

		// argb copy with black key; alpha does not take part in the match
		apply_setting(ckab_pkg::MODE_ARGB, 1'b1, 24'h000000);
		send_pixel(32'h12000000, 32'habcdef01, 1'b0);
		send_pixel(32'h00000001, 32'hffffffff, 1'b0);
		send_pixel(32'hff000000, 32'h00000000, 1'b1);

		// blend: keyed, opaque, clear, alpha extremes, saturation, equal channels
		apply_setting(ckab_pkg::MODE_BLEND, 1'b1, 24'hffffff);
		send_pixel(32'hffffffff, 32'h00000000, 1'b0);
		send_pixel(32'hff123456, 32'h00abcdef, 1'b0);
		send_pixel(32'h00123456, 32'hffabcdef, 1'b0);
		send_pixel(32'h01ff00ff, 32'h0000ff00, 1'b0);
		send_pixel(32'hfe00ff00, 32'hffff00ff, 1'b0);
		send_pixel(32'h80ff8001, 32'h80017fff, 1'b1);
		send_pixel(32'h7f0a0b0c, 32'h000a0b0c, 1'b0);

		// mode code 3 blends; keying off so a key match is still written
		apply_setting(MODE_BLEND_ALT, 1'b0, 24'hffffff);
		send_pixel(32'h40102030, 32'hc0302010, 1'b0);
		send_pixel(32'hc1ffffff, 32'h3e000000, 1'b1);

		phase = 0;
		while (sent_count < PIXEL_TOTAL) begin
			case (phase)
				0: begin mode = ckab_pkg::MODE_INDEX8; en = 1'b1; key = 24'h000000; end
				1: begin mode = ckab_pkg::MODE_ARGB;   en = 1'b1; key = 24'hffffff; end
				2: begin mode = ckab_pkg::MODE_BLEND;  en = 1'b1; key = 24'h000000; end
				3: begin mode = ckab_pkg::MODE_BLEND;  en = 1'b0; key = 24'hffffff; end
				default: begin
					pick = $urandom_range(0, 7);
					mode = pick < 2 ? ckab_pkg::MODE_INDEX8 : pick < 4 ? ckab_pkg::MODE_ARGB :
						pick < 7 ? ckab_pkg::MODE_BLEND : MODE_BLEND_ALT;
					en = $urandom_range(0, 1) != 0;
					case ($urandom_range(0, 3))
						0: key = 24'h000000;
						1: key = 24'hffffff;
						default: begin
							rnd = $urandom();
							key = rnd[ckab_pkg::KEY_W-1:0];
						end
					endcase
				end
			endcase
			apply_setting(mode, en, key);
			phase_idle = $urandom_range(0, 3) != 0;
			count = $urandom_range(30, 60);
			for (int i = 0; i < count && sent_count < PIXEL_TOTAL; i++) begin
				idle_on <= phase_idle && (PIXEL_TOTAL - sent_count > CALM_TAIL);
				send_random_pixel(mode, key);
			end
			phase++;
		end
		drain();

		$display("ran %0d pixels over %0d register settings: index8, argb copy, blend",
			sent_count, setting_count);
		$display("%0d results checked, keying on and off, one %0d-cycle receiver hold-off",
			checked_count, PRESSURE_CYCLES);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ckab_pkg.sv
rtl/core/ckab_if.sv
rtl/core/ckab_compose.sv
rtl/core/colour_key_alpha_blit_pixel.sv
dv/ckab_blit_checker.sv
dv/colour_key_alpha_blit_pixel_tb.sv
